// File: src/ihp_pkg.sv
// Shared types, constants and codes for the interval histogram peak block.
// Used by every module under src; depends on nothing else.
`default_nettype none

package ihp_pkg;

  // Histogram geometry
  localparam int BUCKETS = 64;
  localparam int IDX_W   = $clog2(BUCKETS);
  localparam int CNT_W   = 32;
  localparam int SEEN_W  = CNT_W + IDX_W;

  // Q16 fractions and the products against the sample total
  localparam int FRAC_W = 17;
  localparam int Q_BITS = 16;
  localparam int THR_W  = FRAC_W + CNT_W;

  // floor(ns / 1000000) as (ns * RECIP_MULT) >> RECIP_SHIFT, exact for 32-bit ns
  localparam int          RECIP_W     = 31;
  localparam int          RECIP_SHIFT = 50;
  localparam logic [30:0] RECIP_MULT  = 31'd1125899907;

  localparam int PEAK_MIN_DIST = 2;

  // Input operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Configuration port
  localparam int              CFG_ADDR_W    = 3;
  localparam int              CFG_IDX_W     = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_PCT_FRAC   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_SHARE = 1'd1;
  localparam logic [FRAC_W-1:0] PCT_FRAC_RESET   = 17'd32768;
  localparam logic [FRAC_W-1:0] PEAK_SHARE_RESET = 17'd6554;

  // Second peak code when no peak qualifies
  localparam logic signed [6:0] SP_NONE = -7'sd1;

  typedef struct packed {
    logic [FRAC_W-1:0] pct_frac;
    logic [FRAC_W-1:0] peak_share;
  } ihp_cfg_t;

  typedef struct packed {
    logic             mul_en;
    logic             add_rd;
    logic             add_wr;
    logic             clear;
    logic             q_init;
    logic             rd_en;
    logic [IDX_W-1:0] scan_addr;
    logic             scan1;
    logic             scan2;
    logic             share;
    logic             finish;
  } ihp_cmd_t;

  typedef struct packed {
    logic out_free;
  } ihp_stat_t;

endpackage

`default_nettype wire

// File: src/ihp_cfg.sv
// APB-style register file for the percentile fraction and the minimum peak share.
// Depends on ihp_pkg.
`default_nettype none

module ihp_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ihp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output ihp_pkg::ihp_cfg_t                   cfg_o
);

  logic [ihp_pkg::FRAC_W-1:0]    pct_frac_q;
  logic [ihp_pkg::FRAC_W-1:0]    peak_share_q;
  logic [ihp_pkg::CFG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[ihp_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_frac_q   <= ihp_pkg::PCT_FRAC_RESET;
      peak_share_q <= ihp_pkg::PEAK_SHARE_RESET;
    end else if (wr_en) begin
      if (reg_idx == ihp_pkg::REG_PCT_FRAC) begin
        pct_frac_q <= pwdata[ihp_pkg::FRAC_W-1:0];
      end
      if (reg_idx == ihp_pkg::REG_PEAK_SHARE) begin
        peak_share_q <= pwdata[ihp_pkg::FRAC_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      ihp_pkg::REG_PCT_FRAC:   prdata = 32'(pct_frac_q);
      ihp_pkg::REG_PEAK_SHARE: prdata = 32'(peak_share_q);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.pct_frac   = pct_frac_q;
  assign cfg_o.peak_share = peak_share_q;

endmodule

`default_nettype wire

// File: src/ihp_ctrl.sv
// Sequencer for add, clear and query: input handshake, scan counter, datapath commands.
// Depends on ihp_pkg.
`default_nettype none

module ihp_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  ihp_pkg::ihp_stat_t      stat_i,
  output ihp_pkg::ihp_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD_RD = 3'd1;
  localparam logic [2:0] S_ADD_WR = 3'd2;
  localparam logic [2:0] S_SCAN1  = 3'd3;
  localparam logic [2:0] S_SCAN2  = 3'd4;
  localparam logic [2:0] S_SHARE  = 3'd5;
  localparam logic [2:0] S_FINAL  = 3'd6;

  localparam int                CNT_W   = ihp_pkg::IDX_W + 1;
  localparam logic [CNT_W-1:0]  CNT_END = CNT_W'(ihp_pkg::BUCKETS);

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    cmd_o           = '0;
    cmd_o.scan_addr = cnt_q[ihp_pkg::IDX_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            ihp_pkg::OP_ADD: begin
              cmd_o.mul_en = 1'b1;
              state_d      = S_ADD_RD;
            end
            ihp_pkg::OP_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            ihp_pkg::OP_QUERY: begin
              cmd_o.q_init = 1'b1;
              cnt_d        = '0;
              state_d      = S_SCAN1;
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_IDLE;
      end
      // issue read of cnt, process the data of cnt-1
      S_SCAN1: begin
        cmd_o.rd_en = (cnt_q != CNT_END);
        cmd_o.scan1 = (cnt_q != '0);
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_END) begin
          cnt_d   = '0;
          state_d = S_SCAN2;
        end
      end
      S_SCAN2: begin
        cmd_o.rd_en = (cnt_q != CNT_END);
        cmd_o.scan2 = (cnt_q != '0);
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_END) begin
          cnt_d   = '0;
          state_d = S_SHARE;
        end
      end
      S_SHARE: begin
        cmd_o.share = 1'b1;
        state_d     = S_FINAL;
      end
      // hold until the result register is free
      S_FINAL: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/ihp_dp.sv
// Datapath: bucket memory with valid bits, sample total, scan accumulators, result register.
// Depends on ihp_pkg; driven by ihp_ctrl commands.
`default_nettype none

module ihp_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  ihp_pkg::ihp_cmd_t        cmd_i,
  input  ihp_pkg::ihp_cfg_t        cfg_i,
  input  wire logic [31:0]         interval_ns_i,
  input  wire logic                out_stall_i,
  output ihp_pkg::ihp_stat_t       stat_o,
  output logic                     out_valid_o,
  output logic [5:0]               percentile_bucket_o,
  output logic signed [6:0]        second_peak_o,
  output logic [31:0]              sample_count_o
);

  localparam int IDX_W  = ihp_pkg::IDX_W;
  localparam int CNT_W  = ihp_pkg::CNT_W;
  localparam int SEEN_W = ihp_pkg::SEEN_W;
  localparam int THR_W  = ihp_pkg::THR_W;
  localparam int Q_BITS = ihp_pkg::Q_BITS;
  localparam int PROD_W = 32 + ihp_pkg::RECIP_W;
  localparam int QUO_W  = PROD_W - ihp_pkg::RECIP_SHIFT;
  localparam int CMP_W  = (SEEN_W + Q_BITS > THR_W) ? SEEN_W + Q_BITS : THR_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ihp_pkg::BUCKETS - 1);

  // Bucket memory and valid bits
  logic [CNT_W-1:0]           mem_q [ihp_pkg::BUCKETS];
  logic [ihp_pkg::BUCKETS-1:0] valid_q;
  logic [CNT_W-1:0]           rd_data_q;
  logic                       rd_valid_q;
  logic [IDX_W-1:0]           rd_idx_q;

  logic [PROD_W-1:0] prod_q;
  logic [QUO_W-1:0]  quo;
  logic [IDX_W-1:0]  bucket;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  logic [CNT_W-1:0]  cnt_val;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  total_q;

  // Query state
  logic [THR_W-1:0]  target_q;
  logic [THR_W-1:0]  thr_q;
  logic [SEEN_W-1:0] seen_q;
  logic [SEEN_W-1:0] seen_d;
  logic              found_q;
  logic [IDX_W-1:0]  pidx_q;
  logic [CNT_W-1:0]  max1_q;
  logic [IDX_W-1:0]  m1idx_q;
  logic              have2_q;
  logic [CNT_W-1:0]  max2_q;
  logic [IDX_W-1:0]  m2idx_q;
  logic              ok1_q;
  logic              ok2_q;
  logic [IDX_W-1:0]  peak_gap;
  logic              reached;

  // Result register
  logic                 out_valid_q;
  logic [5:0]           out_pct_q;
  logic signed [6:0]    out_sp_q;
  logic [31:0]          out_total_q;

  assign quo     = prod_q[PROD_W-1:ihp_pkg::RECIP_SHIFT];
  assign bucket  = (quo >= QUO_W'(ihp_pkg::BUCKETS - 1)) ? LAST_IDX : quo[IDX_W-1:0];
  assign rd_addr = cmd_i.add_rd ? bucket : cmd_i.scan_addr;
  assign rd_en   = cmd_i.add_rd || cmd_i.rd_en;

  // Never-written entries read as zero
  assign cnt_val = rd_valid_q ? rd_data_q : '0;
  assign cnt_inc = (cnt_val == '1) ? cnt_val : cnt_val + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(interval_ns_i) * PROD_W'(ihp_pkg::RECIP_MULT);
    end
    if (cmd_i.add_wr) begin
      mem_q[rd_idx_q] <= cnt_inc;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_idx_q   <= '0;
      total_q    <= '0;
    end else begin
      if (cmd_i.clear) begin
        valid_q <= '0;
        total_q <= '0;
      end else if (cmd_i.add_wr) begin
        valid_q[rd_idx_q] <= 1'b1;
        total_q           <= (total_q == '1) ? total_q : total_q + 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
        rd_idx_q   <= rd_addr;
      end
    end
  end

  assign seen_d   = seen_q + SEEN_W'(cnt_val);
  assign reached  = (CMP_W'({seen_d, {Q_BITS{1'b0}}}) >= CMP_W'(target_q));
  assign peak_gap = (rd_idx_q > m1idx_q) ? rd_idx_q - m1idx_q : m1idx_q - rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_init) begin
      target_q <= THR_W'(cfg_i.pct_frac) * THR_W'(total_q);
      thr_q    <= THR_W'(cfg_i.peak_share) * THR_W'(total_q);
      seen_q   <= '0;
      found_q  <= 1'b0;
      pidx_q   <= LAST_IDX;
      max1_q   <= '0;
      m1idx_q  <= '0;
      have2_q  <= 1'b0;
      max2_q   <= '0;
      m2idx_q  <= '0;
    end
    // running sum for the percentile, tallest bucket with ties to the lowest index
    if (cmd_i.scan1) begin
      seen_q <= seen_d;
      if (!found_q && reached) begin
        found_q <= 1'b1;
        pidx_q  <= rd_idx_q;
      end
      if (cnt_val > max1_q) begin
        max1_q  <= cnt_val;
        m1idx_q <= rd_idx_q;
      end
    end
    // skip the tallest bucket and its neighbors
    if (cmd_i.scan2) begin
      if ((peak_gap >= IDX_W'(ihp_pkg::PEAK_MIN_DIST)) && (!have2_q || cnt_val > max2_q)) begin
        have2_q <= 1'b1;
        max2_q  <= cnt_val;
        m2idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.share) begin
      ok1_q <= (CMP_W'({max1_q, {Q_BITS{1'b0}}}) >= CMP_W'(thr_q));
      ok2_q <= (CMP_W'({max2_q, {Q_BITS{1'b0}}}) >= CMP_W'(thr_q));
    end
    if (cmd_i.finish) begin
      out_pct_q   <= (total_q == '0 || !found_q) ? 6'(LAST_IDX) : 6'(pidx_q);
      out_sp_q    <= (total_q == '0 || !have2_q || !ok1_q || !ok2_q) ?
                     ihp_pkg::SP_NONE : 7'(m2idx_q);
      out_total_q <= total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free     = !out_valid_q || !out_stall_i;
  assign out_valid_o         = out_valid_q;
  assign percentile_bucket_o = out_pct_q;
  assign second_peak_o       = out_sp_q;
  assign sample_count_o      = out_total_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while a transfer is pending");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_wr |-> $past(cmd_i.add_rd))
    else $error("bucket write without a preceding read");

  a_total_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.clear) |-> (total_q >= $past(total_q)))
    else $error("sample total dropped without a clear");

  a_peak_needs_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_sp_q != ihp_pkg::SP_NONE)) |-> (out_total_q != '0))
    else $error("second peak reported for an empty histogram");

endmodule

`default_nettype wire

// File: src/interval_histogram_peaks.sv
// Top level of the frame interval histogram with percentile and second peak query.
// Depends on ihp_pkg, ihp_cfg, ihp_ctrl and ihp_dp.
//
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_stall_o  op_i, interval_ns_i
//  out      output     out_valid_o / out_stall_i percentile_bucket_o, second_peak_o,
//                                               sample_count_o
//  cfg      input      APB psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// Add runs a reciprocal multiply, a bucket read and a write back; clear is done from idle.
// Query sweeps the single read port of the bucket memory twice, once for the
// percentile and tallest bucket, once for the second peak.
// Reset and clear drop all bucket valid bits at once; there is no clearing pass.
// A query that finishes while the previous result is still stalled waits for it.
`default_nettype none

module interval_histogram_peaks (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     op_i,
  input  wire logic [31:0]                    interval_ns_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [5:0]                          percentile_bucket_o,
  output logic signed [6:0]                   second_peak_o,
  output logic [31:0]                         sample_count_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ihp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  ihp_pkg::ihp_cfg_t  cfg;
  ihp_pkg::ihp_cmd_t  cmd;
  ihp_pkg::ihp_stat_t stat;

  ihp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ihp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ihp_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_i               (cfg),
    .interval_ns_i       (interval_ns_i),
    .out_stall_i         (out_stall_i),
    .stat_o              (stat),
    .out_valid_o         (out_valid_o),
    .percentile_bucket_o (percentile_bucket_o),
    .second_peak_o       (second_peak_o),
    .sample_count_o      (sample_count_o)
  );

endmodule

`default_nettype wire
